/* rtl/plim_pkg.sv */
// ----------------------------------------------------------------------------
// plim_pkg
// Shared types and constants for the peak limiter with post gain.
// ----------------------------------------------------------------------------
package plim_pkg;

   localparam int SampleW = 24;
   localparam int GainW   = 24;
   localparam int ThreshW = 27;
   localparam int CoefW   = 24;
   localparam int EnvW    = 28;
   localparam int CsrW    = 27;
   localparam int MulAW   = 28;
   localparam int MulBW   = 27;
   localparam int ProdW   = MulAW + MulBW;
   localparam int CntW    = 5;

   localparam logic [GainW-1:0]   GainReset    = 24'd1048576;
   localparam logic [ThreshW-1:0] ThreshReset  = 27'd8388608;
   localparam logic [CoefW-1:0]   CoefReset    = 24'd16773720;
   localparam logic [ThreshW-1:0] ThreshMin    = 27'd8;
   localparam logic [ProdW-1:0]   RoundHalf    = 55'h80000;
   localparam logic [CntW-1:0]    DivLastBit   = 5'd26;
   localparam logic [EnvW-1:0]    PosMax       = 28'h07FFFFF;
   localparam logic [EnvW-1:0]    NegMax       = 28'h0800000;
   localparam logic [SampleW-1:0] SatPos       = 24'h7FFFFF;
   localparam logic [SampleW-1:0] SatNeg       = 24'h800000;

   typedef enum logic [1:0] {
      REG_POST_GAIN   = 2'd0,
      REG_LIMIT_EN    = 2'd1,
      REG_THRESHOLD   = 2'd2,
      REG_RELEASE     = 2'd3
   } reg_idx_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_GAIN   = 7'b0000010,
      ST_ROUND  = 7'b0000100,
      ST_CMP    = 7'b0001000,
      ST_THR    = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

/* rtl/peak_limiter_with_post_gain.sv */
// ----------------------------------------------------------------------------
// peak_limiter_with_post_gain
// Post gain, shared-envelope peak limiter and 24-bit saturation, built around
// one shared 28x27 multiplier and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// An accepted word passes the gain and rounding states, then with the limiter on
// the compare state and, when gain reduction applies, the threshold state and 27
// divider steps, then the finish state. The multiplier and divider sequencer
// handle one word at a time; a new word is accepted only in idle. The result
// register lets the next word start while a result waits. Synchronous active-high
// reset loads register defaults and clears the envelope; no clearing pass.
// ----------------------------------------------------------------------------
module peak_limiter_with_post_gain
   import plim_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,    // [23:0] in_sample
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,    // [23:0] out_sample
   output logic [1:0]         rsp_tuser,    // [0] limiting, [1] clipped
   input  logic               csr_wen,
   input  logic [1:0]         csr_index,
   input  logic [CsrW-1:0]    csr_wdata
);

   state_type            state_ff, state_in;
   logic [GainW-1:0]     gain_ff;
   logic                 enable_ff;
   logic [ThreshW-1:0]   thresh_ff;
   logic [CoefW-1:0]     coef_ff;
   logic [EnvW-1:0]      env_ff, env_in;
   logic                 neg_ff;
   logic [EnvW-1:0]      gmag_ff;
   logic [ProdW-1:0]     prod_ff, prod_in;
   logic [EnvW-1:0]      div_ff;
   logic [EnvW-1:0]      rem_ff, rem_in;
   logic [ThreshW-1:0]   quo_ff, quo_in;
   logic [CntW-1:0]      cnt_ff;
   logic                 lim_ff;
   logic                 rsp_valid_ff;
   logic [SampleW-1:0]   rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   logic [MulAW-1:0]     mul_a;
   logic [MulBW-1:0]     mul_b;
   logic [ThreshW-1:0]   thr_eff;
   logic [EnvW-1:0]      decayed;
   logic [EnvW-1:0]      env_new;
   logic [EnvW:0]        rem_sh;
   logic [EnvW:0]        rem_sub;
   logic [EnvW-1:0]      res_mag;
   logic                 clip;
   logic [SampleW-1:0]   res_data;
   logic                 out_free;
   logic [SampleW-1:0]   in_mag;
   reg_idx_type          csr_sel;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_sel    = reg_idx_type'(csr_index);

   assign in_mag  = req_tdata[23] ? (~req_tdata + 24'd1) : req_tdata;
   assign thr_eff = (thresh_ff < ThreshMin) ? ThreshMin : thresh_ff;
   assign decayed = prod_ff[CoefW +: EnvW];
   assign env_new = (gmag_ff > decayed) ? gmag_ff : decayed;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_GAIN: begin
            mul_a = MulAW'(gmag_ff);
            mul_b = MulBW'(gain_ff);
         end
         ST_ROUND: begin
            mul_a = env_ff;
            mul_b = MulBW'(coef_ff);
         end
         default: begin
            mul_a = gmag_ff;
            mul_b = thr_eff;
         end
      endcase
   end

   // divider step
   assign rem_sh  = {rem_ff, prod_ff[ThreshW-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   // saturation
   assign res_mag = lim_ff ? EnvW'(quo_ff) : gmag_ff;
   assign clip    = neg_ff ? (res_mag > NegMax) : (res_mag > PosMax);
   always_comb begin
      priority if (clip) begin
         res_data = neg_ff ? SatNeg : SatPos;
      end else if (neg_ff) begin
         res_data = ~res_mag[SampleW-1:0] + 24'd1;
      end else begin
         res_data = res_mag[SampleW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      env_in   = env_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            prod_in  = mul_a * mul_b;
            state_in = enable_ff ? ST_CMP : ST_FINISH;
         end
         ST_CMP: begin
            env_in   = env_new;
            state_in = (env_new > EnvW'(thr_eff)) ? ST_THR : ST_FINISH;
         end
         ST_THR: begin
            // numerator high part seeds the remainder
            prod_in  = mul_a * mul_b;
            rem_in   = prod_in[ProdW-1:ThreshW];
            quo_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            prod_in = {prod_ff[ProdW-2:0], 1'b0};
            if (!rem_sub[EnvW]) begin
               rem_in = rem_sub[EnvW-1:0];
               quo_in = {quo_ff[ThreshW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[EnvW-1:0];
               quo_in = {quo_ff[ThreshW-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GainReset;
         enable_ff    <= 1'b0;
         thresh_ff    <= ThreshReset;
         coef_ff      <= CoefReset;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lim_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_sel)
               REG_POST_GAIN: gain_ff <= csr_wdata[GainW-1:0];
               REG_LIMIT_EN: begin
                  enable_ff <= csr_wdata[0];
                  env_ff    <= '0;
               end
               REG_THRESHOLD: begin
                  thresh_ff <= csr_wdata[ThreshW-1:0];
                  env_ff    <= '0;
               end
               REG_RELEASE: begin
                  coef_ff <= csr_wdata[CoefW-1:0];
                  env_ff  <= '0;
               end
               default: ;
            endcase
         end else begin
            env_ff <= env_in;
         end
         if (state_ff == ST_IDLE) begin
            lim_ff <= 1'b0;
         end else if (state_ff == ST_THR) begin
            lim_ff <= 1'b1;
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      if (state_ff == ST_IDLE) begin
         neg_ff  <= req_tdata[23];
         gmag_ff <= EnvW'(in_mag);
      end
      if (state_ff == ST_ROUND) begin
         gmag_ff <= EnvW'((prod_ff + RoundHalf) >> 20);
      end
      if (state_ff == ST_CMP) begin
         div_ff <= env_new;
      end
      if (state_ff == ST_THR) begin
         cnt_ff <= DivLastBit;
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff - 5'd1;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff <= res_data;
         rsp_user_ff <= {clip, lim_ff};
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_GAIN))
      else $error("accepted word did not start the multiply");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == SatPos || rsp_tdata == SatNeg))
      else $error("clipped result is not a rail value");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for peak_limiter_with_post_gain. A directed list of register
// writes and samples comes first, some with results typed in by hand, then
// randomized phases of register settings and samples with random idle cycles
// on both stream sides. Every result word is checked against its typed value
// or an in-bench model of the gain, envelope, divide and saturation math.
// ----------------------------------------------------------------------------
module tb;
   import plim_pkg::*;

   localparam int IdleLimit  = 2000;
   localparam int PhaseCount = 12;
   localparam int PhaseWords = 100;

   typedef struct packed {
      logic [SampleW-1:0] sample;
      logic               limiting;
      logic               clipped;
   } word_type;

   typedef struct {
      logic               is_write;
      reg_idx_type        idx;
      logic [CsrW-1:0]    value;
      logic [SampleW-1:0] sample;
      logic               typed;
      word_type           expected;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [23:0]        req_tdata;    // [23:0] in_sample
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [23:0]        rsp_tdata;    // [23:0] out_sample
   logic [1:0]         rsp_tuser;    // [0] limiting, [1] clipped
   logic               csr_wen;
   logic [1:0]         csr_index;
   logic [CsrW-1:0]    csr_wdata;

   // model copy of the registers and the envelope
   logic [GainW-1:0]   gain_m;
   logic               enable_m;
   logic [ThreshW-1:0] thr_m;
   logic [CoefW-1:0]   coef_m;
   logic [EnvW-1:0]    env_m;

   word_type           pending_words[$];
   plan_row_type       plan[$];
   int                 errors = 0;
   int                 next_gap = 1;
   int                 tx_idle_max = 17;
   int                 rx_idle_max = 17;
   int                 stalled_cycles = 0;

   peak_limiter_with_post_gain dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic word_type limit_word(logic [SampleW-1:0] din);
      longint     s;
      logic       neg;
      logic [63:0] mag;
      logic [63:0] gmag;
      logic [63:0] decayed;
      logic [63:0] peak;
      logic [63:0] thr;
      longint     r;
      word_type   w;
      s = longint'(signed'(din));
      neg = s < 0;
      mag = neg ? 64'(-s) : 64'(s);
      gmag = (mag * 64'(gain_m) + 64'h80000) >> 20;
      w.limiting = 1'b0;
      w.clipped = 1'b0;
      if (enable_m) begin
         decayed = (64'(env_m) * 64'(coef_m)) >> 24;
         peak = (gmag > decayed) ? gmag : decayed;
         thr = (thr_m < ThreshMin) ? 64'(ThreshMin) : 64'(thr_m);
         env_m = peak[EnvW-1:0];
         if (64'(env_m) > thr) begin
            gmag = (gmag * thr) / 64'(env_m);
            w.limiting = 1'b1;
         end
      end
      r = neg ? -longint'(gmag) : longint'(gmag);
      if (r > longint'(SatPos)) begin
         r = longint'(SatPos);
         w.clipped = 1'b1;
      end else if (r < -longint'(NegMax)) begin
         r = -longint'(NegMax);
         w.clipped = 1'b1;
      end
      w.sample = r[SampleW-1:0];
      return w;
   endfunction

   function automatic logic [SampleW-1:0] draw_sample();
      logic [SampleW-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = 24'($urandom);
         4, 5, 6: begin
            v = 24'($urandom_range(0, 4096));
            if ($urandom_range(0, 1)) v = -v;
         end
         7: v = $urandom_range(0, 1) ? SatPos : SatNeg;
         default: begin
            v = 24'(24'h7FFFFF - $urandom_range(0, 65535));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic void plan_write(reg_idx_type idx, logic [CsrW-1:0] v);
      plan_row_type r;
      r.is_write = 1'b1;
      r.idx = idx;
      r.value = v;
      r.sample = '0;
      r.typed = 1'b0;
      r.expected = '0;
      plan.push_back(r);
   endfunction

   function automatic void plan_word(logic [SampleW-1:0] din, logic typed,
                                     logic [SampleW-1:0] s, logic lim, logic clip);
      plan_row_type r;
      r.is_write = 1'b0;
      r.idx = REG_POST_GAIN;
      r.value = '0;
      r.sample = din;
      r.typed = typed;
      r.expected = word_type'({s, lim, clip});
      plan.push_back(r);
   endfunction

   // drop valid if it was left up for a back-to-back word, then drain results
   task automatic wait_idle();
      if (next_gap == 0) begin
         req_tvalid <= 1'b0;
         next_gap = 1;
      end
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [CsrW-1:0] v);
      wait_idle();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_POST_GAIN: gain_m = v[GainW-1:0];
         REG_LIMIT_EN: begin
            enable_m = v[0];
            env_m = '0;
         end
         REG_THRESHOLD: begin
            thr_m = v[ThreshW-1:0];
            env_m = '0;
         end
         REG_RELEASE: begin
            coef_m = v[CoefW-1:0];
            env_m = '0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_word(logic [SampleW-1:0] din, logic typed, word_type typed_word);
      word_type w;
      if (next_gap != 0) repeat (next_gap) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= din;
      do @(posedge clock); while (!req_tready);
      w = limit_word(din);
      pending_words.push_back(typed ? typed_word : w);
      @(negedge clock);
      next_gap = $urandom_range(0, tx_idle_max);
      if (next_gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 24'($urandom);
      end
   endtask

   // result side
   initial begin
      int       stall;
      word_type got;
      word_type exp_w;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, rx_idle_max);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = word_type'({rsp_tdata, rsp_tuser[0], rsp_tuser[1]});
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: sample %h limiting %b clipped %b",
                     $time, got.sample, got.limiting, got.clipped);
         end else begin
            exp_w = pending_words.pop_front();
            if (got !== exp_w) begin
               errors++;
               $display("%0t: mismatch: expected sample %h limiting %b clipped %b, got %h %b %b",
                        $time, exp_w.sample, exp_w.limiting, exp_w.clipped,
                        got.sample, got.limiting, got.clipped);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == IdleLimit) begin
         $display("FAIL peak_limiter_with_post_gain");
         $finish;
      end
   end

   initial begin
      logic [CsrW-1:0] v;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = REG_POST_GAIN;
      csr_wdata = '0;
      gain_m = GainReset;
      enable_m = 1'b0;
      thr_m = ThreshReset;
      coef_m = CoefReset;
      env_m = '0;

      plan_word(24'h000000, 1'b1, 24'h000000, 1'b0, 1'b0);
      plan_word(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0, 1'b0);
      plan_word(24'h800000, 1'b1, 24'h800000, 1'b0, 1'b0);
      plan_word(24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0, 1'b0);
      plan_word(24'h000001, 1'b1, 24'h000001, 1'b0, 1'b0);
      plan_write(REG_POST_GAIN, 27'hFFFFFF);
      plan_word(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0, 1'b1);
      plan_word(24'h800000, 1'b1, 24'h800000, 1'b0, 1'b1);
      plan_word(24'h000000, 1'b1, 24'h000000, 1'b0, 1'b0);
      plan_write(REG_POST_GAIN, 27'h0);
      plan_word(24'h7FFFFF, 1'b1, 24'h000000, 1'b0, 1'b0);
      plan_word(24'h800000, 1'b1, 24'h000000, 1'b0, 1'b0);
      // unity gain with junk above bit 23
      plan_write(REG_POST_GAIN, 27'h7100000);
      plan_word(24'h123456, 1'b1, 24'h123456, 1'b0, 1'b0);
      plan_write(REG_LIMIT_EN, 27'h7FFFFFE);
      plan_word(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0, 1'b0);
      plan_write(REG_LIMIT_EN, 27'h0000003);
      plan_write(REG_THRESHOLD, 27'd4194304);
      plan_word(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'h000064, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'h800000, 1'b0, '0, 1'b0, 1'b0);
      // threshold under the minimum
      plan_write(REG_THRESHOLD, 27'd0);
      plan_word(24'h000005, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0);
      plan_write(REG_RELEASE, 27'd0);
      plan_word(24'h0003E8, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'hFFFC18, 1'b0, '0, 1'b0, 1'b0);
      plan_write(REG_RELEASE, 27'hFFFFFF);
      plan_word(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'h000010, 1'b0, '0, 1'b0, 1'b0);
      plan_write(REG_THRESHOLD, 27'h7FFFFFF);
      plan_word(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0, 1'b0);
      plan_write(REG_POST_GAIN, 27'hFFFFFF);
      plan_word(24'h800000, 1'b0, '0, 1'b0, 1'b0);
      plan_write(REG_THRESHOLD, 27'(ThreshReset));
      plan_word(24'h800000, 1'b0, '0, 1'b0, 1'b0);
      plan_word(24'h7FFFFF, 1'b0, '0, 1'b0, 1'b0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_write)
            write_reg(plan[i].idx, plan[i].value);
         else
            send_word(plan[i].sample, plan[i].typed, plan[i].expected);
      end

      for (int p = 0; p < PhaseCount; p++) begin
         wait_idle();
         tx_idle_max = (p % 3 == 0) ? 0 : 17;
         rx_idle_max = (p % 4 == 1) ? 0 : 17;
         case ($urandom_range(0, 4))
            0: v = 27'(GainReset);
            1: v = '0;
            2: v = 27'hFFFFFF;
            3: v = 27'($urandom);
            default: v = 27'($urandom_range(1 << 19, 1 << 22));
         endcase
         write_reg(REG_POST_GAIN, v);
         v = 27'($urandom);
         v[0] = (p % 4 != 3);
         write_reg(REG_LIMIT_EN, v);
         case ($urandom_range(0, 4))
            0: v = 27'($urandom_range(0, 7));
            1: v = 27'h7FFFFFF;
            2: v = 27'($urandom);
            default: v = 27'($urandom_range(1 << 18, 1 << 23));
         endcase
         write_reg(REG_THRESHOLD, v);
         case ($urandom_range(0, 4))
            0: v = '0;
            1: v = 27'hFFFFFF;
            2: v = 27'($urandom);
            default: v = 27'(24'hFFFFFF - $urandom_range(0, 1 << 16));
         endcase
         write_reg(REG_RELEASE, v);
         repeat (PhaseWords) send_word(draw_sample(), 1'b0, '0);
      end

      wait_idle();
      repeat (60) @(negedge clock);
      if (errors == 0)
         $display("PASS peak_limiter_with_post_gain");
      else
         $display("FAIL peak_limiter_with_post_gain");
      $finish;
   end

endmodule
